// ----- hw/rtl/lsvm_pkg.sv -----
// ----------------------------------------------------------------------------
// lsvm_pkg
// Shared types, codes and helpers of the linear SVM trainer and predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsvm_pkg;

  // default number of features per sample
  localparam int unsigned FEATURE_COUNT_DEF = 2;

  // configuration port geometry
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // register indexes (taken from the word address bit)
  localparam logic REG_LEARNING_RATE = 1'b0;
  localparam logic REG_REGULARIZATION = 1'b1;

  // register reset values, unsigned Q0.16
  localparam logic [15:0] LEARNING_RATE_RST = 16'd655;
  localparam logic [15:0] REGULARIZATION_RST = 16'd66;

  // 1.0 in Q16.16 for the margin test
  localparam int ONE_Q16 = 65536;

  // saturation bounds of the Q16.16 words
  localparam logic signed [47:0] SAT_MAX = 48'sd2147483647;
  localparam logic signed [47:0] SAT_MIN = -48'sd2147483648;

  // input word action codes
  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_TRAIN   = 2'd1,
    ACT_PREDICT = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  // one input word
  typedef struct packed {
    action_e            action;
    logic signed [15:0] feature;
    logic               last_of_sample;
    logic               sample_label;
  } in_word_t;

  // one result word
  typedef struct packed {
    logic               predicted_label;
    logic signed [31:0] score;
    logic               margin_violated;
  } out_word_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_SCORE,
    ST_DECAY,
    ST_STEP,
    ST_WRITE
  } ctrl_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic clear;
    logic load;
    logic mac;
    logic finish;
    logic decay;
    logic step;
    logic write;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic pos_full;
    logic idx_last;
    logic out_free;
    logic train;
  } dp_stat_t;

  // clamp a wide sum into the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lsvm_cfg.sv -----
// ----------------------------------------------------------------------------
// lsvm_cfg
// APB-style register file holding the learning rate and the decay factor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsvm_cfg (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [lsvm_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire  [lsvm_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [lsvm_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic [15:0]                       eta_o,
  output logic [15:0]                       lam_o
);
  import lsvm_pkg::*;

  logic        reg_idx;
  logic        wr_en;
  logic [15:0] eta_q;
  logic [15:0] lam_q;

  // word address decode
  assign reg_idx = paddr[CFG_ADDR_W-1];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eta_q <= LEARNING_RATE_RST;
      lam_q <= REGULARIZATION_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LEARNING_RATE:  eta_q <= pwdata[15:0];
        REG_REGULARIZATION: lam_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      REG_LEARNING_RATE:  prdata = {{(CFG_DATA_W-16){1'b0}}, eta_q};
      REG_REGULARIZATION: prdata = {{(CFG_DATA_W-16){1'b0}}, lam_q};
      default:            prdata = '0;
    endcase
  end

  assign eta_o = eta_q;
  assign lam_o = lam_q;

endmodule

`default_nettype wire

// ----- hw/rtl/lsvm_ctrl.sv -----
// ----------------------------------------------------------------------------
// lsvm_ctrl
// Sequencer: accepts words, runs the accumulate, score and update walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsvm_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  input  lsvm_pkg::action_e     in_action_i,
  input  wire                   in_last_i,
  output logic                  in_stall_o,
  input  lsvm_pkg::dp_stat_t    stat_i,
  output lsvm_pkg::dp_cmd_t     cmd_o
);
  import lsvm_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        last_q, last_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    last_d     = last_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          unique case (in_action_i) inside
            ACT_CLEAR: begin
              cmd_o.clear = 1'b1;
            end
            ACT_TRAIN, ACT_PREDICT: begin
              cmd_o.load = 1'b1;
              last_d     = in_last_i;
              if (!stat_i.pos_full) begin
                state_d = ST_MAC;
              end else if (in_last_i) begin
                state_d = ST_SCORE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        cmd_o.mac = 1'b1;
        state_d   = last_q ? ST_SCORE : ST_IDLE;
      end
      ST_SCORE: begin
        // wait for room in the output register
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = stat_i.train ? ST_DECAY : ST_IDLE;
        end
      end
      ST_DECAY: begin
        cmd_o.decay = 1'b1;
        state_d     = ST_STEP;
      end
      ST_STEP: begin
        cmd_o.step = 1'b1;
        state_d    = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = stat_i.idx_last ? ST_IDLE : ST_DECAY;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lsvm_dpath.sv -----
// ----------------------------------------------------------------------------
// lsvm_dpath
// Weights, bias, sample buffer, accumulator, update multipliers and output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsvm_dpath #(
  parameter int unsigned FEATURE_COUNT = lsvm_pkg::FEATURE_COUNT_DEF
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  lsvm_pkg::in_word_t    in_word_i,
  input  wire  [15:0]           eta_i,
  input  wire  [15:0]           lam_i,
  input  lsvm_pkg::dp_cmd_t     cmd_i,
  output lsvm_pkg::dp_stat_t    stat_o,
  input  wire                   out_stall_i,
  output logic                  out_valid_o,
  output lsvm_pkg::out_word_t   out_word_o
);
  import lsvm_pkg::*;

  localparam int unsigned CNT_W = $clog2(FEATURE_COUNT + 1);
  localparam int unsigned IDX_W = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
  localparam logic [CNT_W-1:0] POS_MAX  = CNT_W'(FEATURE_COUNT);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FEATURE_COUNT - 1);

  // model state
  logic signed [31:0] weight_q [FEATURE_COUNT];
  logic signed [31:0] bias_q;
  logic signed [15:0] sample_q [FEATURE_COUNT];
  logic [CNT_W-1:0]   pos_q;
  logic signed [47:0] acc_q;

  // working registers
  logic signed [47:0] prod_q;
  logic [IDX_W-1:0]   idx_q;
  logic               train_q, fit_q, violated_q;
  logic [15:0]        eta_q, lam_q;
  logic signed [48:0] decay_prod_q;
  logic signed [51:0] step_prod_q;
  logic               out_valid_q;
  out_word_t          out_word_q;

  // combinational terms
  logic               pos_full;
  logic [IDX_W-1:0]   pos_idx;
  logic signed [47:0] mac_prod;
  logic signed [47:0] score_sum;
  logic signed [48:0] score_ext;
  logic signed [48:0] margin;
  logic               violated;
  logic signed [31:0] w_idx;
  logic signed [15:0] x_sel;
  logic signed [19:0] xq;
  logic signed [20:0] xq_ext;
  logic signed [20:0] term;
  logic signed [33:0] decay;
  logic signed [34:0] diff;
  logic signed [35:0] step;
  logic signed [47:0] w_sum;
  logic signed [47:0] eta_ext;
  logic signed [47:0] bias_sum;
  logic               idx_last;

  assign pos_full = (pos_q == POS_MAX);
  assign pos_idx  = pos_q[IDX_W-1:0];
  assign idx_last = (idx_q == IDX_LAST);

  // feature times weight, Q20.28
  assign mac_prod = weight_q[pos_idx] * in_word_i.feature;

  // score and margin from the unsaturated sum
  assign score_sum = acc_q + $signed({{16{bias_q[31]}}, bias_q});
  assign score_ext = $signed({score_sum[47], score_sum});
  assign margin    = fit_q ? score_ext : -score_ext;
  assign violated  = (margin < ONE_Q16);

  // decay term, floor(2*lambda*w / 2^16)
  assign w_idx = weight_q[idx_q];
  assign decay = 34'(decay_prod_q >>> 15);

  // sample term, zero when the margin held or for features the sample did not give
  assign x_sel  = (violated_q && ({{(CNT_W-IDX_W){1'b0}}, idx_q} < pos_q))
                  ? sample_q[idx_q] : 16'sd0;
  assign xq     = $signed({x_sel, 4'b0000});
  assign xq_ext = xq;
  assign term   = fit_q ? xq_ext : -xq_ext;
  assign diff   = term - decay;

  // weight and bias sums before clamping
  assign step     = 36'(step_prod_q >>> 16);
  assign w_sum    = w_idx + step;
  assign eta_ext  = $signed({32'd0, eta_q});
  assign bias_sum = fit_q ? ($signed({{16{bias_q[31]}}, bias_q}) + eta_ext)
                          : ($signed({{16{bias_q[31]}}, bias_q}) - eta_ext);

  // weights and bias
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FEATURE_COUNT; i++) begin
        weight_q[i] <= '0;
      end
      bias_q <= '0;
    end else if (cmd_i.clear) begin
      for (int i = 0; i < FEATURE_COUNT; i++) begin
        weight_q[i] <= '0;
      end
      bias_q <= '0;
    end else if (cmd_i.write) begin
      weight_q[idx_q] <= sat32(w_sum);
      if (idx_last && violated_q) begin
        bias_q <= sat32(bias_sum);
      end
    end
  end

  // sample position, accumulator and walk index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      acc_q <= '0;
      idx_q <= '0;
    end else if (cmd_i.clear) begin
      pos_q <= '0;
      acc_q <= '0;
      idx_q <= '0;
    end else if (cmd_i.load) begin
      if (!pos_full) begin
        pos_q <= pos_q + 1'b1;
      end
    end else if (cmd_i.mac) begin
      acc_q <= acc_q + (prod_q >>> 12);
    end else if (cmd_i.finish) begin
      idx_q <= '0;
      if (!train_q) begin
        pos_q <= '0;
        acc_q <= '0;
      end
    end else if (cmd_i.write) begin
      if (idx_last) begin
        idx_q <= '0;
        pos_q <= '0;
        acc_q <= '0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // sample buffer and product capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !pos_full) begin
      sample_q[pos_idx] <= in_word_i.feature;
      prod_q            <= mac_prod;
    end
  end

  // mode of the sample, taken from its latest word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      train_q <= (in_word_i.action == ACT_TRAIN);
      fit_q   <= in_word_i.sample_label;
    end
  end

  // rates and margin held for the update walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      eta_q      <= eta_i;
      lam_q      <= lam_i;
      violated_q <= violated;
    end
  end

  // update multipliers, one register after each
  always_ff @(posedge clk_i) begin
    if (cmd_i.decay) begin
      decay_prod_q <= $signed({1'b0, lam_q}) * w_idx;
    end
    if (cmd_i.step) begin
      step_prod_q <= $signed({1'b0, eta_q}) * diff;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_word_q.predicted_label <= (score_sum > 48'sd0);
      out_word_q.score           <= sat32(score_sum);
      out_word_q.margin_violated <= train_q && violated;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // status to the controller
  assign stat_o.pos_full = pos_full;
  assign stat_o.idx_last = idx_last;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;
  assign stat_o.train    = train_q;

endmodule

`default_nettype wire

// ----- hw/rtl/linear_svm_sgd_train_predict.sv -----
// ----------------------------------------------------------------------------
// linear_svm_sgd_train_predict
// Linear SVM with online hinge-loss SGD training and L2 weight decay.
//
// Input words carry one feature each; the word flagged last_of_sample ends
// the sample and produces one result word (label, Q16.16 score, margin flag).
// Action clear zeroes the model; the unused action is dropped.
// Learning rate and decay factor sit behind the APB port at 0x0 and 0x4.
//
// Flow: a feature word is taken in idle and added to the accumulator in the
// MAC state; a word past the last feature slot skips that step. After the
// last word the score state forms the result once the output register has
// room. A predict sample then frees the input at once; a train sample
// first walks the weights through the shared decay and step multipliers,
// with a decay, step and write state per weight, and the input stalls
// until the walk is done.
// The result waits in an output register while out_stall_i is high; a new
// result is not formed until it is taken, and the input stalls meanwhile.
// Reset clears weights, bias and accumulator and loads the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module linear_svm_sgd_train_predict #(
  parameter int unsigned FEATURE_COUNT = lsvm_pkg::FEATURE_COUNT_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // input channel
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  lsvm_pkg::in_word_t                in_word_i,
  // result channel
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output lsvm_pkg::out_word_t               out_word_o,
  // configuration port
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [lsvm_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire  [lsvm_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [lsvm_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import lsvm_pkg::*;

  logic [15:0] eta;
  logic [15:0] lam;
  dp_cmd_t     cmd;
  dp_stat_t    stat;

  // register file
  lsvm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .eta_o   (eta),
    .lam_o   (lam)
  );

  // sequencer
  lsvm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_word_i.action),
    .in_last_i   (in_word_i.last_of_sample),
    .in_stall_o  (in_stall_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath
  lsvm_dpath #(
    .FEATURE_COUNT (FEATURE_COUNT)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .eta_i       (eta),
    .lam_i       (lam),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/lsvm_checker.sv -----
// ----------------------------------------------------------------------------
// lsvm_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsvm_checker (
  input wire                   clk_i,
  input wire                   rst_ni,
  input wire                   in_valid_i,
  input wire                   in_stall_o,
  input lsvm_pkg::in_word_t    in_word_i,
  input wire                   out_valid_o,
  input wire                   out_stall_i,
  input lsvm_pkg::out_word_t   out_word_o
);
  import lsvm_pkg::*;

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result holds its word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_word_o))
    else $error("result word changed while stalled");

  // label agrees with the sign of the score
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_word_o.predicted_label == (!out_word_o.score[31] && out_word_o.score != 32'sd0))
    else $error("label disagrees with score sign");

  // no result is formed in the cycle a word is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_word_i.action != ACT_NONE |=> !$rose(out_valid_o))
    else $error("result formed too early");

endmodule

bind linear_svm_sgd_train_predict lsvm_checker u_checker (.*);

`default_nettype wire

// ----- verif/linear_svm_sgd_train_predict_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_svm_sgd_train_predict_checker
// Watches the input, result and APB traffic of the SVM trainer. It keeps its
// own copy of weights, bias and step sizes, works out each result word from
// the accepted input words, and compares the words that come out field by
// field, in order.
// ----------------------------------------------------------------------------
module linear_svm_sgd_train_predict_checker #(
  parameter int unsigned FEATURE_COUNT = lsvm_pkg::FEATURE_COUNT_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  input  wire                            in_stall_i,
  input  lsvm_pkg::in_word_t             in_word_i,
  input  wire                            out_valid_i,
  input  wire                            out_stall_i,
  input  lsvm_pkg::out_word_t            out_word_i,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire [lsvm_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire [lsvm_pkg::CFG_DATA_W-1:0] pwdata,
  input  wire                            pready,
  output int                             fail_count_o,
  output int                             pending_o
);
  import lsvm_pkg::*;

  localparam longint Q16_TOP = 64'sd2147483647;
  localparam longint Q16_BOTTOM = -64'sd2147483648;

  // step sizes as seen through the APB port
  longint             rate_q;
  longint             decay_q;

  // model and per-sample state
  logic signed [31:0] coef [FEATURE_COUNT];
  logic signed [31:0] offset_q;
  logic signed [15:0] held_x [FEATURE_COUNT];
  int unsigned        slot;
  longint             acc_sum;

  out_word_t          awaited_results [$];
  int                 errs;

  // clamp into the Q16.16 word range
  function automatic logic signed [31:0] clamp32(input longint v);
    logic signed [31:0] r;
    if (v > Q16_TOP) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < Q16_BOTTOM) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

  task automatic wipe_sample();
    for (int f = 0; f < FEATURE_COUNT; f++) begin
      held_x[f] = '0;
    end
    slot = 0;
    acc_sum = 0;
  endtask

  task automatic wipe_model();
    for (int f = 0; f < FEATURE_COUNT; f++) begin
      coef[f] = '0;
    end
    offset_q = '0;
    wipe_sample();
  endtask

  // accumulate one feature; at the end of a sample score it and, when
  // training, take one hinge-loss step
  task automatic score_and_learn(input in_word_t w);
    longint    total;
    longint    margin;
    longint    wf;
    longint    decay;
    longint    term;
    logic      viol;
    out_word_t r;
    case (w.action) inside
      ACT_CLEAR: begin
        wipe_model();
      end
      ACT_TRAIN, ACT_PREDICT: begin
        // features past the model width are dropped
        if (slot < FEATURE_COUNT) begin
          held_x[slot] = w.feature;
          acc_sum += (longint'(coef[slot]) * longint'($signed(w.feature))) >>> 12;
          slot++;
        end
        if (w.last_of_sample) begin
          total = acc_sum + longint'(offset_q);
          r.predicted_label = (total > 0);
          r.score = clamp32(total);
          r.margin_violated = 1'b0;
          // last word's action decides whether the model learns
          if (w.action == ACT_TRAIN) begin
            margin = w.sample_label ? total : -total;
            viol = (margin < ONE_Q16);
            r.margin_violated = viol;
            for (int f = 0; f < FEATURE_COUNT; f++) begin
              wf = longint'(coef[f]);
              decay = (2 * decay_q * wf) >>> 16;
              term = 0;
              if (viol) begin
                term = longint'(held_x[f]) * 16;
                if (!w.sample_label) begin
                  term = -term;
                end
              end
              coef[f] = clamp32(wf + ((rate_q * (term - decay)) >>> 16));
            end
            if (viol) begin
              offset_q = clamp32(longint'(offset_q) + (w.sample_label ? rate_q : -rate_q));
            end
          end
          awaited_results.push_back(r);
          wipe_sample();
        end
      end
      default: begin
        // unused action leaves everything alone
      end
    endcase
  endtask

  // compare one result word with the oldest one awaited
  task automatic match_word(input out_word_t got);
    out_word_t want;
    if (awaited_results.size() == 0) begin
      errs++;
      $display("%0t: result word expected none got label %0b score %0d flag %0b",
               $time, got.predicted_label, $signed(got.score), got.margin_violated);
    end else begin
      want = awaited_results.pop_front();
      if (got.predicted_label !== want.predicted_label) begin
        errs++;
        $display("%0t: predicted_label expected %0b got %0b",
                 $time, want.predicted_label, got.predicted_label);
      end
      if (got.score !== want.score) begin
        errs++;
        $display("%0t: score expected %0d got %0d",
                 $time, $signed(want.score), $signed(got.score));
      end
      if (got.margin_violated !== want.margin_violated) begin
        errs++;
        $display("%0t: margin_violated expected %0b got %0b",
                 $time, want.margin_violated, got.margin_violated);
      end
    end
  endtask

  // watch all three ports at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q = longint'(LEARNING_RATE_RST);
      decay_q = longint'(REGULARIZATION_RST);
      wipe_model();
      awaited_results.delete();
      errs = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_REGULARIZATION) begin
          decay_q = longint'(pwdata[15:0]);
        end else begin
          rate_q = longint'(pwdata[15:0]);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        score_and_learn(in_word_i);
      end
      if (out_valid_i && !out_stall_i) begin
        match_word(out_word_i);
      end
      fail_count_o <= errs;
      pending_o <= awaited_results.size();
    end
  end

endmodule

// ----- verif/linear_svm_sgd_train_predict_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_svm_sgd_train_predict_tb
// Drives the SVM trainer with a short directed run and then random samples
// over several step-size settings, with random gaps on both channels, one
// long result hold-off and one drain pause. The checker beside the block
// predicts and compares; this top only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module linear_svm_sgd_train_predict_tb;
  import lsvm_pkg::*;

  localparam int unsigned FC = FEATURE_COUNT_DEF;
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned PHASES = 6;
  localparam int unsigned SETTLE_CYCLES = 3 + 3 * FC + 16;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // how often a side idles
  typedef enum int unsigned {
    PACE_NONE,
    PACE_FULL,
    PACE_SPARSE
  } pace_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_word_t              in_word = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_word;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int                    fail_count;
  int                    pending;
  int unsigned           cycles = 0;
  int unsigned           words_sent = 0;
  pace_e                 send_pace = PACE_NONE;
  pace_e                 recv_pace = PACE_SPARSE;
  bit                    hold_request = 1'b0;

  linear_svm_sgd_train_predict #(
    .FEATURE_COUNT(FC)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  linear_svm_sgd_train_predict_checker #(
    .FEATURE_COUNT(FC)
  ) u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_word_i  (out_word),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("linear_svm_sgd_train_predict_tb: errors");
    $finish;
  end

  function automatic int unsigned draw_gap(input pace_e pace);
    int unsigned n;
    case (pace)
      PACE_NONE: n = 0;
      PACE_FULL: n = $urandom_range(0, 17);
      default:   n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
    endcase
    return n;
  endfunction

  function automatic in_word_t mk_word(input action_e a, input logic [15:0] x,
                                       input logic last, input logic lbl);
    in_word_t w;
    w.action = a;
    w.feature = x;
    w.last_of_sample = last;
    w.sample_label = lbl;
    return w;
  endfunction

  // extremes, values near the margin, and the full range
  function automatic logic [15:0] draw_feature();
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0:       v = 16'h7FFF;
      1:       v = 16'h8000;
      2:       v = 16'h0000;
      3, 4, 5: v = 16'($urandom_range(0, 16383)) - 16'd8192;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // offer one word after a random gap, hold it until taken
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    gap = draw_gap(send_pace);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    if (w.action != ACT_NONE) begin
      words_sent++;
    end
  endtask

  // one sample with random content; sometimes short, too long, mixed,
  // broken by a clear, or salted with dropped words
  task automatic send_sample();
    int unsigned len;
    int unsigned roll;
    action_e     mode;
    logic        lbl;
    in_word_t    w;
    mode = ($urandom_range(0, 2) == 0) ? ACT_PREDICT : ACT_TRAIN;
    lbl = 1'($urandom);
    case ($urandom_range(0, 9))
      0:       len = FC + $urandom_range(1, 2);
      1, 2:    len = $urandom_range(1, FC);
      default: len = FC;
    endcase
    for (int unsigned i = 0; i < len; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        send_word(mk_word(ACT_NONE, 16'($urandom), 1'($urandom), 1'($urandom)));
      end else if (roll == 5) begin
        send_word(mk_word(ACT_CLEAR, 16'($urandom), 1'($urandom), 1'($urandom)));
      end
      w = mk_word(mode, draw_feature(), i == len - 1, lbl);
      if (i != len - 1) begin
        w.sample_label = 1'($urandom);
        if ($urandom_range(0, 4) == 0) begin
          w.action = (mode == ACT_TRAIN) ? ACT_PREDICT : ACT_TRAIN;
        end
      end
      send_word(w);
    end
  endtask

  // stop offering and let every awaited result and the update walk finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // apb write: setup cycle, access cycle
  task automatic cfg_write(input logic idx, input logic [CFG_DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // result side: random stall per word, one long hold-off on request
  initial begin
    int unsigned wait_n;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        wait_n = HOLD_CYCLES;
      end else begin
        wait_n = draw_gap(recv_pace);
      end
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      @(posedge clk_i);
      while (!out_valid || out_stall) @(posedge clk_i);
    end
  end

  // stimulus and verdict
  initial begin
    logic [CFG_DATA_W-1:0] rates [PHASES];
    logic [CFG_DATA_W-1:0] decays [PHASES];
    int unsigned           phase_start;
    bit                    paused;
    rates = '{32'h0000_FFFF, 32'h0000_0000, 32'($urandom_range(0, 65535)),
              32'h0000_FFFF, 32'd4000, {16'($urandom), 16'd1500}};
    decays = '{32'h0000_0000, 32'h0000_FFFF, 32'($urandom_range(0, 65535)),
               32'h0000_FFFF, 32'd300, {16'($urandom), 16'd40}};
    paused = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset step sizes
    send_pace = PACE_NONE;
    recv_pace = PACE_SPARSE;
    // full samples with extreme features, both labels
    send_word(mk_word(ACT_TRAIN, 16'h7FFF, 1'b0, 1'b1));
    send_word(mk_word(ACT_TRAIN, 16'h8000, 1'b1, 1'b1));
    send_word(mk_word(ACT_TRAIN, 16'h8000, 1'b0, 1'b0));
    send_word(mk_word(ACT_TRAIN, 16'h7FFF, 1'b1, 1'b0));
    // prediction, label has no effect
    send_word(mk_word(ACT_PREDICT, 16'h1000, 1'b0, 1'b1));
    send_word(mk_word(ACT_PREDICT, 16'hF000, 1'b1, 1'b0));
    send_word(mk_word(ACT_PREDICT, 16'h1000, 1'b0, 1'b0));
    send_word(mk_word(ACT_PREDICT, 16'hF000, 1'b1, 1'b1));
    // unused action is dropped
    send_word(mk_word(ACT_NONE, 16'hFFFF, 1'b1, 1'b1));
    // more features than the model holds
    send_word(mk_word(ACT_TRAIN, 16'h0100, 1'b0, 1'b1));
    send_word(mk_word(ACT_TRAIN, 16'h0200, 1'b0, 1'b1));
    send_word(mk_word(ACT_TRAIN, 16'h7FFF, 1'b1, 1'b1));
    // short sample
    send_word(mk_word(ACT_TRAIN, 16'h2000, 1'b1, 1'b1));
    // mixed actions, last word decides
    send_word(mk_word(ACT_PREDICT, 16'h3000, 1'b0, 1'b1));
    send_word(mk_word(ACT_TRAIN, 16'hD000, 1'b1, 1'b0));
    send_word(mk_word(ACT_TRAIN, 16'h0800, 1'b0, 1'b1));
    send_word(mk_word(ACT_PREDICT, 16'h0800, 1'b1, 1'b1));
    // clear, then a zero model scores zero
    send_word(mk_word(ACT_CLEAR, 16'h5555, 1'b1, 1'b1));
    send_word(mk_word(ACT_PREDICT, 16'h0000, 1'b0, 1'b0));
    send_word(mk_word(ACT_PREDICT, 16'h0000, 1'b1, 1'b0));
    send_word(mk_word(ACT_TRAIN, 16'h0000, 1'b0, 1'b1));
    send_word(mk_word(ACT_TRAIN, 16'h0000, 1'b1, 1'b1));
    settle();

    // random phases, step sizes changed only while idle
    for (int unsigned p = 0; p < PHASES; p++) begin
      cfg_write(REG_LEARNING_RATE, rates[p]);
      cfg_write(REG_REGULARIZATION, decays[p]);
      send_pace = pace_e'(p % 3);
      recv_pace = pace_e'((p + 1) % 3);
      if (p == 2) begin
        hold_request = 1'b1;
      end
      phase_start = words_sent;
      while (words_sent - phase_start < RANDOM_ITEMS / PHASES) begin
        send_sample();
        // sender waits for every result once mid-phase
        if (p == 4 && !paused && words_sent - phase_start >= RANDOM_ITEMS / (2 * PHASES)) begin
          settle();
          paused = 1'b1;
        end
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("linear_svm_sgd_train_predict_tb: clean");
    end else begin
      $display("linear_svm_sgd_train_predict_tb: errors");
    end
    $finish;
  end

endmodule
